// ===== rtl/dllm_pkg.sv =====
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and codes for the doubly linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    // Fixed field widths of the request and result ports
    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int RID_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 2'd0,
        REQ_REMOVE    = 2'd1,
        REQ_FIND_SLOT = 2'd2,
        REQ_FIND_ID   = 2'd3
    } t_req;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE   = 2'd0,
        STAT_NULL   = 2'd1,
        STAT_REJECT = 2'd2
    } t_status;

endpackage

// ===== rtl/dllm_ram.sv =====
// ----------------------------------------------------------------------------
// dllm_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module dllm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/doubly_linked_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_unit
// Keeps one doubly linked list over a pool of node slots. Links and ids
// live in three RAMs (prev, next, id); membership marks, head, tail and
// count live in flops.
// ----------------------------------------------------------------------------
//
//  channel   ports                                          transfer when
//  -------   ---------------------------------------------  ---------------------
//  request   i_req_type i_node_null i_node_slot             start && !busy
//            i_resource_id
//  result    o_status o_found o_found_slot o_list_count     o_result_strobe
//
//  The result appears in the cycle after the last cycle of work on a request.
//  Find slot, null and rejected requests: never busy, result next cycle.
//  Append: an extra state (ST_APP_LINK) links the old tail when the list was not empty.
//  Remove: the prev/next RAM read comes before the relinking state ST_RM_UPD.
//  Find by id: walks the listed slots from the head, one id/next RAM read per
//  cycle. No clearing pass after reset.
//  The result strobe is high for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_unit #(
    parameter int NODE_SLOTS = 64,
    parameter int ID_BITS    = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dllm_pkg::REQ_W-1:0]   i_req_type,
    input  logic                         i_node_null,
    input  logic [dllm_pkg::SLOT_W-1:0]  i_node_slot,
    input  logic [dllm_pkg::RID_W-1:0]   i_resource_id,
    output logic                         o_result_strobe,
    output logic [dllm_pkg::STATUS_W-1:0] o_status,
    output logic                         o_found,
    output logic [dllm_pkg::SLOT_W-1:0]  o_found_slot,
    output logic [dllm_pkg::COUNT_W-1:0] o_list_count
);

    import dllm_pkg::*;

    localparam int AW = $clog2(NODE_SLOTS);
    localparam int LW = $clog2(NODE_SLOTS + 1);
    localparam logic [LW-1:0] NullLink = LW'(NODE_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APP_LINK,
        ST_RM_UPD,
        ST_FIND
    } t_state;

    // Registers
    t_state              r_state;
    logic [LW-1:0]       r_head;
    logic [LW-1:0]       r_tail;
    logic [LW-1:0]       r_count;
    logic [NODE_SLOTS-1:0] r_mark;
    logic [AW-1:0]       r_slot;
    logic [LW-1:0]       r_link;
    logic [LW-1:0]       r_cur;
    logic [LW-1:0]       r_steps;
    logic [ID_BITS-1:0]  r_rid;
    logic                r_strobe;
    t_status             r_status;
    logic                r_found;
    logic [SLOT_W-1:0]   r_fslot;
    logic [COUNT_W-1:0]  r_out_count;

    // Next values
    t_state              n_state;
    logic [LW-1:0]       n_head;
    logic [LW-1:0]       n_tail;
    logic [LW-1:0]       n_count;
    logic [NODE_SLOTS-1:0] n_mark;
    logic [AW-1:0]       n_slot;
    logic [LW-1:0]       n_link;
    logic [LW-1:0]       n_cur;
    logic [LW-1:0]       n_steps;
    logic [ID_BITS-1:0]  n_rid;
    logic                n_strobe;
    t_status             n_status;
    logic                n_found;
    logic [SLOT_W-1:0]   n_fslot;

    // RAM ports
    logic                prev_we;
    logic [AW-1:0]       prev_waddr;
    logic [LW-1:0]       prev_wdata;
    logic [LW-1:0]       prev_rd;
    logic                next_we;
    logic [AW-1:0]       next_waddr;
    logic [LW-1:0]       next_wdata;
    logic [LW-1:0]       next_rd;
    logic                id_we;
    logic [ID_BITS-1:0]  id_rd;
    logic [AW-1:0]       rd_addr;

    // Request decode
    logic                accept;
    t_req                req;
    logic                slot_ok;
    logic [AW-1:0]       slot_idx;
    logic                slot_listed;
    logic [ID_BITS-1:0]  w_rid;
    logic                prev_ok;
    logic                next_ok;
    logic [LW-1:0]       steps_inc;

    assign accept      = start && !busy;
    assign req         = t_req'(i_req_type);
    assign slot_ok     = 32'(i_node_slot) < NODE_SLOTS;
    assign slot_idx    = AW'(i_node_slot);
    assign slot_listed = slot_ok && r_mark[slot_idx];
    assign w_rid       = ID_BITS'(i_resource_id);
    assign prev_ok     = prev_rd < NullLink;
    assign next_ok     = next_rd < NullLink;
    assign steps_inc   = r_steps + LW'(1);

    // Link and id RAMs
    dllm_ram #(.DEPTH(NODE_SLOTS), .WIDTH(LW)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (rd_addr),
        .o_rdata (prev_rd)
    );

    dllm_ram #(.DEPTH(NODE_SLOTS), .WIDTH(LW)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (rd_addr),
        .o_rdata (next_rd)
    );

    dllm_ram #(.DEPTH(NODE_SLOTS), .WIDTH(ID_BITS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (slot_idx),
        .i_wdata (w_rid),
        .i_raddr (rd_addr),
        .o_rdata (id_rd)
    );

    // Request sequencing and RAM access control
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_mark     = r_mark;
        n_slot     = r_slot;
        n_link     = r_link;
        n_cur      = r_cur;
        n_steps    = r_steps;
        n_rid      = r_rid;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        n_fslot    = r_fslot;
        prev_we    = 1'b0;
        prev_waddr = slot_idx;
        prev_wdata = r_tail;
        next_we    = 1'b0;
        next_waddr = slot_idx;
        next_wdata = NullLink;
        id_we      = 1'b0;
        rd_addr    = (req == REQ_REMOVE) ? slot_idx : r_head[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = STAT_DONE;
                    n_found  = 1'b0;
                    n_fslot  = '0;
                    n_slot   = slot_idx;
                    n_rid    = w_rid;
                    if (req == REQ_FIND_ID) begin
                        // start the walk at the head
                        n_cur   = r_head;
                        n_steps = '0;
                        if (r_head < NullLink && r_count != '0) begin
                            n_state = ST_FIND;
                        end else begin
                            n_strobe = 1'b1;
                        end
                    end else if (i_node_null) begin
                        n_status = STAT_NULL;
                        n_strobe = 1'b1;
                    end else begin
                        case (req)
                            REQ_FIND_SLOT: begin
                                n_found  = slot_listed;
                                n_fslot  = slot_listed ? i_node_slot : '0;
                                n_strobe = 1'b1;
                            end
                            REQ_APPEND: begin
                                if (!slot_ok || slot_listed ||
                                    32'(r_count) >= NODE_SLOTS) begin
                                    n_status = STAT_REJECT;
                                    n_strobe = 1'b1;
                                end else begin
                                    // new node: prev = old tail, next = null
                                    prev_we  = 1'b1;
                                    next_we  = 1'b1;
                                    id_we    = 1'b1;
                                    n_mark[slot_idx] = 1'b1;
                                    n_count  = r_count + LW'(1);
                                    n_tail   = LW'(i_node_slot);
                                    n_link   = r_tail;
                                    if (r_tail < NullLink) begin
                                        n_state = ST_APP_LINK;
                                    end else begin
                                        n_head   = LW'(i_node_slot);
                                        n_strobe = 1'b1;
                                    end
                                end
                            end
                            REQ_REMOVE: begin
                                if (!slot_listed || r_count == '0) begin
                                    n_status = STAT_REJECT;
                                    n_strobe = 1'b1;
                                end else begin
                                    // prev/next of the slot are read now
                                    n_state = ST_RM_UPD;
                                end
                            end
                            default: begin
                                n_strobe = 1'b1;
                            end
                        endcase
                    end
                end
            end

            ST_APP_LINK: begin
                // old tail now points at the new node
                next_we    = 1'b1;
                next_waddr = r_link[AW-1:0];
                next_wdata = LW'(r_slot);
                n_strobe   = 1'b1;
                n_state    = ST_IDLE;
            end

            ST_RM_UPD: begin
                // splice the neighbors together
                next_waddr = prev_rd[AW-1:0];
                next_wdata = next_rd;
                prev_waddr = next_rd[AW-1:0];
                prev_wdata = prev_rd;
                if (prev_ok) begin
                    next_we = 1'b1;
                end else begin
                    n_head = next_rd;
                end
                if (next_ok) begin
                    prev_we = 1'b1;
                end else begin
                    n_tail = prev_rd;
                end
                n_mark[r_slot] = 1'b0;
                n_count  = r_count - LW'(1);
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end

            ST_FIND: begin
                // id and next of r_cur are on the read ports
                rd_addr = next_rd[AW-1:0];
                if (id_rd == r_rid) begin
                    n_found  = 1'b1;
                    n_fslot  = SLOT_W'(r_cur);
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else if (next_ok && steps_inc < r_count) begin
                    n_cur   = next_rd;
                    n_steps = steps_inc;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= NullLink;
            r_tail   <= NullLink;
            r_count  <= '0;
            r_mark   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_mark   <= n_mark;
            r_strobe <= n_strobe;
        end
        r_slot      <= n_slot;
        r_link      <= n_link;
        r_cur       <= n_cur;
        r_steps     <= n_steps;
        r_rid       <= n_rid;
        r_status    <= n_status;
        r_found     <= n_found;
        r_fslot     <= n_fslot;
        r_out_count <= COUNT_W'(n_count);
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_found_slot    = r_fslot;
    assign o_list_count    = r_out_count;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for doubly_linked_list_manager_unit. A behavioral list
// model predicts status, found flag, found slot and list count for every
// accepted request. A monitor compares each strobed result with the oldest
// prediction. Directed cases come first, then three random phases with
// different sender idle rates and append/remove mixes.
// ----------------------------------------------------------------------------
module testbench;

    import dllm_pkg::*;

    localparam int          SLOTS   = 64;
    localparam logic [6:0]  NO_LINK = 7'd64;
    localparam int          MAX_GAP = 24;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [SLOT_W-1:0]   found_slot;
        logic [COUNT_W-1:0]  list_count;
    } t_list_result;

    // DUT ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [REQ_W-1:0]     i_req_type = '0;
    logic                 i_node_null = 1'b0;
    logic [SLOT_W-1:0]    i_node_slot = '0;
    logic [RID_W-1:0]     i_resource_id = '0;
    logic                 o_result_strobe;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_found;
    logic [SLOT_W-1:0]    o_found_slot;
    logic [COUNT_W-1:0]   o_list_count;

    // List model state
    logic [6:0]           head_q;
    logic [6:0]           tail_q;
    logic [6:0]           entry_total;
    logic [6:0]           prev_q [SLOTS];
    logic [6:0]           next_q [SLOTS];
    logic [RID_W-1:0]     slot_id [SLOTS];
    logic                 on_list [SLOTS];

    // Predicted results waiting for the DUT
    t_list_result         pending_results [$];

    int                   idle_pct = 0;
    int                   fail_count = 0;
    int                   results_checked = 0;
    int                   req_count [4];
    int                   hit_count = 0;
    int                   reject_count = 0;
    int                   null_count = 0;
    int                   deepest = 0;

    doubly_linked_list_manager_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_node_null     (i_node_null),
        .i_node_slot     (i_node_slot),
        .i_resource_id   (i_resource_id),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_found_slot    (o_found_slot),
        .o_list_count    (o_list_count)
    );

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("doubly_linked_list_manager_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // List model
    // ------------------------------------------------------------------------
    function automatic void clear_list_model();
        head_q      = NO_LINK;
        tail_q      = NO_LINK;
        entry_total = '0;
        for (int i = 0; i < SLOTS; i++) begin
            prev_q[i]  = '0;
            next_q[i]  = '0;
            slot_id[i] = '0;
            on_list[i] = 1'b0;
        end
    endfunction

    // Applies one request to the model and returns the result it should give
    function automatic t_list_result apply_list_request(t_req req, logic is_null,
                                                        logic [SLOT_W-1:0] slot,
                                                        logic [RID_W-1:0] rid);
        t_list_result r;
        logic [6:0]   cur;
        logic [6:0]   p;
        logic [6:0]   n;
        int           steps;
        logic         hit;
        r        = '0;
        r.status = STAT_DONE;
        if (req == REQ_FIND_ID) begin
            // walk from the head, bounded by the entry count
            cur   = head_q;
            steps = 0;
            hit   = 1'b0;
            while (!hit && cur < NO_LINK && steps < int'(entry_total)) begin
                if (slot_id[cur[SLOT_W-1:0]] == rid) begin
                    hit          = 1'b1;
                    r.found      = 1'b1;
                    r.found_slot = cur[SLOT_W-1:0];
                end else begin
                    cur   = next_q[cur[SLOT_W-1:0]];
                    steps = steps + 1;
                end
            end
        end else if (is_null) begin
            r.status = STAT_NULL;
        end else if (req == REQ_FIND_SLOT) begin
            if (on_list[slot]) begin
                r.found      = 1'b1;
                r.found_slot = slot;
            end
        end else if (req == REQ_APPEND) begin
            if (on_list[slot] || entry_total >= NO_LINK) begin
                r.status = STAT_REJECT;
            end else begin
                if (tail_q != NO_LINK) next_q[tail_q[SLOT_W-1:0]] = {1'b0, slot};
                else                   head_q = {1'b0, slot};
                prev_q[slot]  = tail_q;
                next_q[slot]  = NO_LINK;
                tail_q        = {1'b0, slot};
                slot_id[slot] = rid;
                on_list[slot] = 1'b1;
                entry_total   = entry_total + 7'd1;
            end
        end else begin
            if (!on_list[slot] || entry_total == '0) begin
                r.status = STAT_REJECT;
            end else begin
                p = prev_q[slot];
                n = next_q[slot];
                if (p != NO_LINK) next_q[p[SLOT_W-1:0]] = n;
                else              head_q = n;
                if (n != NO_LINK) prev_q[n[SLOT_W-1:0]] = p;
                else              tail_q = p;
                on_list[slot] = 1'b0;
                entry_total   = entry_total - 7'd1;
            end
        end
        r.list_count = entry_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One request transfer, with a random idle gap ahead of it
    task automatic issue_request(input t_req req, input logic is_null,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [RID_W-1:0] rid);
        int           gap;
        t_list_result res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type    <= req;
        i_node_null   <= is_null;
        i_node_slot   <= slot;
        i_resource_id <= rid;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        res = apply_list_request(req, is_null, slot, rid);
        pending_results.push_back(res);
        req_count[int'(req)]++;
        if (res.found)                 hit_count++;
        if (res.status == STAT_REJECT) reject_count++;
        if (res.status == STAT_NULL)   null_count++;
        if (int'(res.list_count) > deepest) deepest = int'(res.list_count);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a slot with the given membership, starting at a random point
    function automatic logic [SLOT_W-1:0] pick_slot(logic want_listed);
        int base;
        int s;
        base = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            s = (base + i) % SLOTS;
            if (on_list[s[SLOT_W-1:0]] == want_listed) return s[SLOT_W-1:0];
        end
        return base[SLOT_W-1:0];
    endfunction

    // Ids from a small pool make duplicates likely; extremes and full range too
    function automatic logic [RID_W-1:0] pick_id();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(input int append_pct, input int remove_pct);
        int                 r;
        logic               is_null;
        logic [SLOT_W-1:0]  slot;
        logic [RID_W-1:0]   rid;
        t_req               req;
        r       = $urandom_range(99);
        is_null = ($urandom_range(99) < 4);
        slot    = SLOT_W'($urandom);
        rid     = pick_id();
        if (r < append_pct) begin
            req = REQ_APPEND;
            if ($urandom_range(9) < 8) slot = pick_slot(1'b0);
        end else if (r < append_pct + remove_pct) begin
            req = REQ_REMOVE;
            if ($urandom_range(99) < 85) slot = pick_slot(1'b1);
        end else if (r < append_pct + remove_pct + 15) begin
            req = REQ_FIND_SLOT;
            if ($urandom_range(1) == 0) slot = pick_slot(1'b1);
        end else begin
            req = REQ_FIND_ID;
            // mostly search for an id that is on the list
            if ($urandom_range(99) < 60 && entry_total != '0) rid = slot_id[pick_slot(1'b1)];
        end
        issue_request(req, is_null, slot, rid);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_result_strobe) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result with nothing expected: st=%0d f=%0d s=%0d n=%0d",
                                       o_status, o_found, o_found_slot, o_list_count));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_found !== want.found ||
                    o_found_slot !== want.found_slot || o_list_count !== want.list_count)
                    note_failure($sformatf(
                        "exp st=%0d f=%0d s=%0d n=%0d, got st=%0d f=%0d s=%0d n=%0d",
                        want.status, want.found, want.found_slot, want.list_count,
                        o_status, o_found, o_found_slot, o_list_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Requests against an empty list
    task automatic test_empty_list();
        issue_request(REQ_FIND_ID,   1'b0, 6'd0,  '0);
        issue_request(REQ_REMOVE,    1'b0, 6'd0,  '0);
        issue_request(REQ_FIND_SLOT, 1'b0, 6'd63, '0);
    endtask

    // Null node is ignored, except for find by id where it does not matter
    task automatic test_null_node();
        issue_request(REQ_APPEND,    1'b1, 6'd5,  32'h1234_5678);
        issue_request(REQ_REMOVE,    1'b1, 6'd5,  '0);
        issue_request(REQ_FIND_SLOT, 1'b1, 6'd5,  '0);
        issue_request(REQ_FIND_ID,   1'b1, 6'd63, 32'h1234_5678);
    endtask

    // Appends at the id extremes, a duplicate id, and a second append of a slot
    task automatic test_append_and_find();
        issue_request(REQ_APPEND,    1'b0, 6'd0,  32'h0000_0000);
        issue_request(REQ_APPEND,    1'b0, 6'd63, 32'hFFFF_FFFF);
        issue_request(REQ_APPEND,    1'b0, 6'd17, 32'h0000_A5A5);
        issue_request(REQ_APPEND,    1'b0, 6'd42, 32'h0000_A5A5);
        issue_request(REQ_APPEND,    1'b0, 6'd0,  32'h5A5A_5A5A);
        issue_request(REQ_FIND_SLOT, 1'b0, 6'd63, '0);
        issue_request(REQ_FIND_ID,   1'b0, 6'd9,  32'h0000_A5A5);
        issue_request(REQ_FIND_ID,   1'b0, 6'd0,  32'hFFFF_FFFF);
        issue_request(REQ_FIND_ID,   1'b0, 6'd0,  32'h0000_0000);
    endtask

    // Unlink from the middle, head and tail, then empty the list
    task automatic test_unlink();
        issue_request(REQ_REMOVE,    1'b0, 6'd17, '0);
        issue_request(REQ_FIND_ID,   1'b0, 6'd0,  32'h0000_A5A5);
        issue_request(REQ_REMOVE,    1'b0, 6'd0,  '0);
        issue_request(REQ_REMOVE,    1'b0, 6'd42, '0);
        issue_request(REQ_REMOVE,    1'b0, 6'd42, '0);
        issue_request(REQ_FIND_SLOT, 1'b0, 6'd42, '0);
        issue_request(REQ_REMOVE,    1'b0, 6'd63, '0);
        issue_request(REQ_FIND_ID,   1'b0, 6'd0,  32'hFFFF_FFFF);
    endtask

    // Random traffic with a given idle rate and operation mix
    task automatic test_random_phase(input int pct, input int append_pct,
                                     input int remove_pct, input int items);
        idle_pct = pct;
        for (int i = 0; i < items; i++) begin
            if (i == items / 2) wait_drained();
            random_request(append_pct, remove_pct);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < 4; i++) req_count[i] = 0;
        clear_list_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 37;
        test_empty_list();
        test_null_node();
        test_append_and_find();
        test_unlink();
        wait_drained();

        // fill toward a full list, drain toward empty, then a balanced mix
        test_random_phase(37, 55, 15, 420);
        test_random_phase(63, 20, 55, 420);
        test_random_phase(0,  35, 30, 420);

        repeat (80) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d appends, %0d removes, %0d slot finds, %0d id walks; %0d checked",
                 req_count[0], req_count[1], req_count[2], req_count[3], results_checked);
        $display("Hits %0d, rejects %0d, null nodes %0d, deepest list %0d, mismatches %0d",
                 hit_count, reject_count, null_count, deepest, fail_count);
        if (fail_count == 0) begin
            $display("doubly_linked_list_manager_unit test passed");
        end else begin
            $display("doubly_linked_list_manager_unit test failed");
        end
        $finish;
    end

endmodule
